FILE: hw/rtl/fpq_pkg.sv
`timescale 1ns / 1ps

package fpq_pkg;

  localparam int SlotCount = 16;
  localparam int Levels    = 32;

  localparam int SlotW      = $clog2(SlotCount);
  localparam int UsedW      = SlotW + 1;
  localparam int LevelW     = $clog2(Levels);
  localparam int ActionW    = 3;
  localparam int CpuIdW     = 8;
  localparam int SlotFieldW = 4;
  localparam int PriW       = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_ALLOCATE = 3'd0,
    ACT_ENQUEUE  = 3'd1,
    ACT_BLOCK    = 3'd2,
    ACT_UNBLOCK  = 3'd3,
    ACT_YIELD    = 3'd4,
    ACT_SCHEDULE = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HEAD,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic [ActionW-1:0]    action;
    logic [CpuIdW-1:0]     cpu_id;
    logic [SlotFieldW-1:0] slot;
    logic [PriW-1:0]       priority_req;
    logic                  cpu_asleep;
    logic                  running_valid;
    logic [CpuIdW-1:0]     running_id;
    logic [PriW-1:0]       running_priority;
  } item_t;

  typedef struct packed {
    logic                  chosen_valid;
    logic [CpuIdW-1:0]     chosen_id;
    logic [SlotFieldW-1:0] given_slot;
    logic                  alloc_failed;
    logic                  reschedule;
  } result_t;

  typedef struct packed {
    logic              re;
    logic [LevelW-1:0] addr;
    logic              head_we;
    logic              tail_we;
    logic [SlotW-1:0]  head_data;
    logic [SlotW-1:0]  tail_data;
    logic              set_ne;
    logic              clr_ne;
  } lvl_req_t;

  typedef struct packed {
    logic [SlotW-1:0] head;
    logic [SlotW-1:0] tail;
  } lvl_rsp_t;

  typedef struct packed {
    logic              re;
    logic [SlotW-1:0]  addr;
    logic              owner_we;
    logic [CpuIdW-1:0] owner_data;
    logic              next_we;
    logic [SlotW-1:0]  next_data;
  } slot_req_t;

  typedef struct packed {
    logic [CpuIdW-1:0] owner;
    logic [SlotW-1:0]  next;
  } slot_rsp_t;

  function automatic logic [LevelW-1:0] clamp_level(logic [PriW-1:0] p);
    logic [LevelW-1:0] lv;
    if (int'(p) >= Levels) lv = LevelW'(Levels - 1);
    else lv = LevelW'(p);
    return lv;
  endfunction

  function automatic logic slot_in_pool(logic [SlotFieldW-1:0] s);
    return int'(s) < SlotCount;
  endfunction

endpackage

FILE: hw/rtl/fpq_if.sv
`timescale 1ns / 1ps

interface fpq_in_if import fpq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ActionW-1:0]    action;
  logic [CpuIdW-1:0]     cpu_id;
  logic [SlotFieldW-1:0] slot;
  logic [PriW-1:0]       priority_req;
  logic                  cpu_asleep;
  logic                  running_valid;
  logic [CpuIdW-1:0]     running_id;
  logic [PriW-1:0]       running_priority;

  modport source (
    output valid, action, cpu_id, slot, priority_req, cpu_asleep,
           running_valid, running_id, running_priority,
    input  ready
  );
  modport sink (
    input  valid, action, cpu_id, slot, priority_req, cpu_asleep,
           running_valid, running_id, running_priority,
    output ready
  );
endinterface

interface fpq_out_if import fpq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  chosen_valid;
  logic [CpuIdW-1:0]     chosen_id;
  logic [SlotFieldW-1:0] given_slot;
  logic                  alloc_failed;
  logic                  reschedule;

  modport source (
    output valid, chosen_valid, chosen_id, given_slot, alloc_failed, reschedule,
    input  ready
  );
  modport sink (
    input  valid, chosen_valid, chosen_id, given_slot, alloc_failed, reschedule,
    output ready
  );
endinterface

FILE: hw/rtl/fpq_level_table.sv
`timescale 1ns / 1ps

module fpq_level_table import fpq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lvl_req_t          req_i,
  output lvl_rsp_t          rsp_o,
  output logic [Levels-1:0] nonempty_o
);

  logic [SlotW-1:0]  head_mem [Levels];
  logic [SlotW-1:0]  tail_mem [Levels];
  lvl_rsp_t          rsp_q;
  logic [Levels-1:0] nonempty_q;

  always_ff @(posedge clk_i) begin
    if (req_i.head_we) head_mem[req_i.addr] <= req_i.head_data;
    if (req_i.tail_we) tail_mem[req_i.addr] <= req_i.tail_data;
    if (req_i.re) begin
      rsp_q.head <= head_mem[req_i.addr];
      rsp_q.tail <= tail_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
    end else if (req_i.set_ne) begin
      nonempty_q[req_i.addr] <= 1'b1;
    end else if (req_i.clr_ne) begin
      nonempty_q[req_i.addr] <= 1'b0;
    end
  end

  assign rsp_o      = rsp_q;
  assign nonempty_o = nonempty_q;

endmodule

FILE: hw/rtl/fpq_slot_table.sv
`timescale 1ns / 1ps

module fpq_slot_table import fpq_pkg::*; (
  input  logic      clk_i,
  input  slot_req_t req_i,
  output slot_rsp_t rsp_o
);

  logic [CpuIdW-1:0] owner_mem [SlotCount];
  logic [SlotW-1:0]  next_mem  [SlotCount];
  slot_rsp_t         rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.owner_we) owner_mem[req_i.addr] <= req_i.owner_data;
    if (req_i.next_we) next_mem[req_i.addr] <= req_i.next_data;
    if (req_i.re) begin
      rsp_q.owner <= owner_mem[req_i.addr];
      rsp_q.next  <= next_mem[req_i.addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: hw/rtl/fixed_priority_ready_queues_core.sv
// Ready-queue scheduler: one item in flight, handled by a small sequencer around
// the level table (head/tail) and the slot table (owner/link), each with a registered read.
// Item flow: capture, execute, head read (popping schedule), commit once output is free.
// No new item is taken before the commit; a popping schedule does two dependent reads.
// A waiting result sits in an output register while the next item is taken.
// Reset: empty levels, no slots handed out; table contents stay undefined until written.
`timescale 1ns / 1ps

module fixed_priority_ready_queues_core import fpq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  fpq_in_if.sink     in_i,
  fpq_out_if.source  out_o
);

  fsm_e              state_q, state_d;
  item_t             item_q, item_d;
  logic [LevelW-1:0] lv_q, lv_d;
  logic [UsedW-1:0]  slots_used_q, slots_used_d;
  result_t           res_q, res_d;
  logic              out_valid_q;
  logic              out_load;
  logic              out_free;

  lvl_req_t          lvl_req;
  lvl_rsp_t          lvl_rsp;
  logic [Levels-1:0] nonempty;
  slot_req_t         slot_req;
  slot_rsp_t         slot_rsp;

  logic [LevelW-1:0] item_lv;
  logic [LevelW-1:0] top_lv;
  logic [LevelW-1:0] enc_lv;
  logic              enc_found;
  logic              is_append;
  logic              slot_ok;

  fpq_level_table u_level_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (lvl_req),
    .rsp_o      (lvl_rsp),
    .nonempty_o (nonempty)
  );

  fpq_slot_table u_slot_table (
    .clk_i (clk_i),
    .req_i (slot_req),
    .rsp_o (slot_rsp)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign item_lv  = clamp_level(item_q.priority_req);
  assign slot_ok  = slot_in_pool(item_q.slot);
  assign top_lv   = item_q.running_valid ? clamp_level(item_q.running_priority)
                                         : LevelW'(Levels - 1);
  assign is_append = (action_e'(item_q.action) == ACT_ENQUEUE) ||
                     (action_e'(item_q.action) == ACT_BLOCK) ||
                     ((action_e'(item_q.action) == ACT_UNBLOCK) && item_q.cpu_asleep);

  // Most urgent non-empty level no deeper than the running CPU
  always_comb begin
    enc_found = 1'b0;
    enc_lv    = '0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (nonempty[i] && (LevelW'(i) <= top_lv)) begin
        enc_found = 1'b1;
        enc_lv    = LevelW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    lv_d         = lv_q;
    slots_used_d = slots_used_q;
    res_d        = res_q;
    out_load     = 1'b0;
    lvl_req      = '0;
    slot_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          item_d.action           = in_i.action;
          item_d.cpu_id           = in_i.cpu_id;
          item_d.slot             = in_i.slot;
          item_d.priority_req     = in_i.priority_req;
          item_d.cpu_asleep       = in_i.cpu_asleep;
          item_d.running_valid    = in_i.running_valid;
          item_d.running_id       = in_i.running_id;
          item_d.running_priority = in_i.running_priority;
          state_d                 = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        if (action_e'(item_q.action) == ACT_SCHEDULE) begin
          lv_d = enc_lv;
          if (enc_found) begin
            lvl_req.re   = 1'b1;
            lvl_req.addr = enc_lv;
            state_d      = ST_HEAD;
          end
        end else begin
          lv_d = item_lv;
          // fetch the tail to link behind it
          if (is_append && slot_ok && nonempty[item_lv]) begin
            lvl_req.re   = 1'b1;
            lvl_req.addr = item_lv;
          end
        end
      end
      ST_HEAD: begin
        slot_req.re   = 1'b1;
        slot_req.addr = lvl_rsp.head;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          res_d    = '0;
          unique case (action_e'(item_q.action))
            ACT_ALLOCATE: begin
              if (slots_used_q < UsedW'(SlotCount)) begin
                slot_req.owner_we   = 1'b1;
                slot_req.addr       = SlotW'(slots_used_q);
                slot_req.owner_data = item_q.cpu_id;
                res_d.given_slot    = SlotFieldW'(slots_used_q);
                slots_used_d        = slots_used_q + UsedW'(1);
              end else begin
                res_d.alloc_failed = 1'b1;
              end
            end
            ACT_ENQUEUE, ACT_BLOCK, ACT_UNBLOCK: begin
              res_d.reschedule = (action_e'(item_q.action) != ACT_ENQUEUE) && is_append;
              if (is_append && slot_ok) begin
                lvl_req.addr      = lv_q;
                lvl_req.tail_we   = 1'b1;
                lvl_req.tail_data = SlotW'(item_q.slot);
                if (nonempty[lv_q]) begin
                  slot_req.next_we   = 1'b1;
                  slot_req.addr      = lvl_rsp.tail;
                  slot_req.next_data = SlotW'(item_q.slot);
                end else begin
                  lvl_req.head_we   = 1'b1;
                  lvl_req.head_data = SlotW'(item_q.slot);
                  lvl_req.set_ne    = 1'b1;
                end
              end
            end
            ACT_YIELD: begin
              res_d.reschedule = 1'b1;
            end
            ACT_SCHEDULE: begin
              if (nonempty[lv_q] && (lv_q <= top_lv)) begin
                // pop the head; drop the level when it held one slot
                lvl_req.addr = lv_q;
                if (lvl_rsp.head == lvl_rsp.tail) begin
                  lvl_req.clr_ne = 1'b1;
                end else begin
                  lvl_req.head_we   = 1'b1;
                  lvl_req.head_data = slot_rsp.next;
                end
                res_d.chosen_valid = 1'b1;
                res_d.chosen_id    = slot_rsp.owner;
              end else if (item_q.running_valid) begin
                res_d.chosen_valid = 1'b1;
                res_d.chosen_id    = item_q.running_id;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slots_used_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slots_used_q <= slots_used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    lv_q   <= lv_d;
    res_q  <= res_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.chosen_valid = res_q.chosen_valid;
  assign out_o.chosen_id    = res_q.chosen_id;
  assign out_o.given_slot   = res_q.given_slot;
  assign out_o.alloc_failed = res_q.alloc_failed;
  assign out_o.reschedule   = res_q.reschedule;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q <= UsedW'(SlotCount))
    else $error("slot pool count overran");

  a_write_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_req.head_we || lvl_req.tail_we || slot_req.owner_we || slot_req.next_we)
      |-> (state_q == ST_DONE && out_free))
    else $error("table written outside commit");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("commit did not present a result");

  a_read_then_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_req.re |=> (state_q == ST_HEAD || state_q == ST_DONE))
    else $error("level read issued without a consumer");

endmodule
